// ===== hdl/stack_blur_row_pass_top_defines.svh =====
// Assertion macros used by the row blur sequencer.
`ifndef STACK_BLUR_ROW_PASS_TOP_DEFINES_SVH
`define STACK_BLUR_ROW_PASS_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbr_pkg.sv =====
// Types and constants shared by the row blur modules.
package sbr_pkg;

  localparam int RADIUS_W  = 6;
  localparam int TAP_W     = RADIUS_W + 1;
  localparam int WEIGHT_W  = RADIUS_W + 1;
  localparam int CH_W      = 8;
  localparam int NUM_LANES = 3;
  localparam int PIX_W     = CH_W * NUM_LANES;
  localparam int QBITS     = CH_W;
  localparam int QCNT_W    = $clog2(QBITS);

  localparam logic [RADIUS_W-1:0] RADIUS_MIN   = RADIUS_W'(3);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV,
    ST_EMIT
  } sbr_state_t;

  // Control broadcast from the sequencer to every channel lane.
  typedef struct packed {
    logic                clear;
    logic                acc;
    logic [WEIGHT_W-1:0] weight;
    logic                div_start;
  } lane_ctl_t;

  // Control from the sequencer to the pixel window.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } win_ctl_t;

endpackage

// ===== hdl/sbr_window.sv =====
// Circular pixel window: newest pixel at the write pointer, taps read by offset.
module sbr_window import sbr_pkg::*; #(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  win_ctl_t          ctl,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_offset,
  output logic [PIX_W-1:0]  rd_data
);

  localparam int MEM_DEPTH = 1 << ADDR_W;

  logic [PIX_W-1:0]  mem [MEM_DEPTH];
  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] wp_next;

  assign wp_next = wp + 1'b1;

  // Write pointer advances once per accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (ctl.wr_en) begin
      wp <= wp_next;
    end
  end

  // Pixel storage; the address wraps modulo the power-of-two depth.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wp_next] <= wr_data;
    end
  end

  // Registered tap read, offset counted back from the newest pixel.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[wp - rd_offset];
    end
  end

endmodule

// ===== hdl/sbr_lane.sv =====
// One color channel: weighted tap accumulator and an eight-step restoring divider.
module sbr_lane import sbr_pkg::*; #(
  parameter int SUM_W = 19,
  parameter int DIV_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  logic [CH_W-1:0]  pixel,
  input  logic [DIV_W-1:0] divisor,
  output logic [QBITS-1:0] quotient,
  output logic             done
);

  localparam int TW = SUM_W + QBITS;

  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  rem;
  logic [QCNT_W-1:0] bit_idx;
  logic              busy;
  logic [TW-1:0]     trial;
  logic              ge;
  logic [CH_W+WEIGHT_W-1:0] prod;

  assign prod  = pixel * ctl.weight;
  assign trial = TW'(divisor) << bit_idx;
  assign ge    = TW'(rem) >= trial;

  // Divider sequencing: one quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_idx <= '0;
    end else if (ctl.div_start) begin
      busy    <= 1'b1;
      done    <= 1'b0;
      bit_idx <= QCNT_W'(QBITS - 1);
    end else if (busy) begin
      if (bit_idx == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      bit_idx <= bit_idx - 1'b1;
    end
  end

  // Accumulator and divider datapath.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc) begin
      acc <= acc + SUM_W'(prod);
    end
    if (ctl.div_start) begin
      rem      <= acc;
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - SUM_W'(trial);
      end
      quotient <= {quotient[QBITS-2:0], ge};
    end
  end

endmodule

// ===== hdl/sbr_merge.sv =====
// Output register that merges the lane quotients into one result word.
module sbr_merge import sbr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [CH_W-1:0] quot [NUM_LANES],
  input  logic            last,
  output logic            free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0] red_out,
  output logic [CH_W-1:0] green_out,
  output logic [CH_W-1:0] blue_out,
  output logic            row_end_out
);

  assign free = !out_valid || !out_stall;

  // Valid flag: set on load, cleared once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, lane 0 is red, lane 1 green, lane 2 blue.
  always_ff @(posedge clk) begin
    if (load) begin
      red_out     <= quot[0];
      green_out   <= quot[1];
      blue_out    <= quot[2];
      row_end_out <= last;
    end
  end

endmodule

// ===== hdl/sbr_ctrl.sv =====
// Sequencer: radius register, row position, tap walk, divide and emit control.
`include "stack_blur_row_pass_top_defines.svh"

module sbr_ctrl import sbr_pkg::*; #(
  parameter int MAX_RADIUS = 32,
  parameter int ADDR_W     = 7,
  parameter int POS_W      = 7,
  parameter int DIV_W      = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [RADIUS_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                row_end_in,
  output win_ctl_t            win_ctl,
  output logic [ADDR_W-1:0]   rd_offset,
  output lane_ctl_t           lane_ctl,
  output logic [DIV_W-1:0]    divisor,
  input  logic                div_done,
  input  logic                merge_free,
  output logic                merge_load,
  output logic                merge_last
);

  localparam int POS_CAP = 2 * MAX_RADIUS + 1;
  localparam int CW      = (POS_W > RADIUS_W) ? POS_W : RADIUS_W;
  localparam int KW      = (POS_W > TAP_W) ? POS_W : TAP_W;
  localparam int MW      = (RADIUS_W + 1 > 8) ? RADIUS_W + 1 : 8;

  sbr_state_t          state;
  sbr_state_t          state_next;
  logic [RADIUS_W-1:0] radius;
  logic [POS_W-1:0]    row_pos;
  logic [POS_W-1:0]    x_lat;
  logic                last_lat;
  logic [RADIUS_W-1:0] d_cnt;
  logic [RADIUS_W-1:0] d_start;
  logic [TAP_W-1:0]    j_cnt;
  logic                acc_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic                accept;
  logic                need_result;
  logic                j_last;
  logic                more_results;
  logic [TAP_W-1:0]    t_span;
  logic [TAP_W-1:0]    k_raw;
  logic [KW-1:0]       k_clamp;
  logic [WEIGHT_W-1:0] weight_now;
  logic [TAP_W-1:0]    rp1;
  logic                radius_ok;

  assign in_stall     = (state != ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign need_result  = row_end_in || (CW'(row_pos) >= CW'(radius));
  assign d_start      = (CW'(row_pos) < CW'(radius)) ? RADIUS_W'(row_pos) : radius;
  assign j_last       = (j_cnt == {radius, 1'b0});
  assign more_results = last_lat && (d_cnt != '0);
  assign rp1          = TAP_W'(radius) + 1'b1;
  assign radius_ok    = (radius >= RADIUS_MIN) && (MW'(radius) <= MW'(MAX_RADIUS));

  // Tap offset back from the newest pixel, replicated at both segment edges.
  always_comb begin
    t_span = TAP_W'(d_cnt) + TAP_W'(radius);
    if (j_cnt >= t_span) begin
      k_raw = '0;
    end else begin
      k_raw = t_span - j_cnt;
    end
    if (KW'(k_raw) > KW'(x_lat)) begin
      k_clamp = KW'(x_lat);
    end else begin
      k_clamp = KW'(k_raw);
    end
  end

  // Triangle weight: rises 1..r+1, then falls back to 1.
  always_comb begin
    if (j_cnt <= TAP_W'(radius)) begin
      weight_now = WEIGHT_W'(j_cnt + 1'b1);
    end else begin
      weight_now = WEIGHT_W'({radius, 1'b1} - j_cnt);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && need_result) begin
          state_next = ST_TAPS;
        end
      end
      ST_TAPS: begin
        if (j_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:     state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (merge_free) begin
          state_next = more_results ? ST_TAPS : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    win_ctl.wr_en      = accept;
    win_ctl.rd_en      = (state == ST_TAPS);
    rd_offset          = ADDR_W'(k_clamp);
    lane_ctl.clear     = (state == ST_TAPS) && (j_cnt == '0);
    lane_ctl.acc       = acc_q;
    lane_ctl.weight    = weight_q;
    lane_ctl.div_start = (state == ST_DIV_START);
    merge_load         = (state == ST_EMIT) && merge_free;
    merge_last         = last_lat && (d_cnt == '0);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      radius  <= RADIUS_RESET;
      row_pos <= '0;
      acc_q   <= 1'b0;
    end else begin
      state <= state_next;
      acc_q <= (state == ST_TAPS);
      // Radius writes below the minimum are dropped; large ones saturate.
      if (cfg_write && (cfg_data >= RADIUS_MIN)) begin
        if (MW'(cfg_data) > MW'(MAX_RADIUS)) begin
          radius <= RADIUS_W'(MAX_RADIUS);
        end else begin
          radius <= cfg_data;
        end
      end
      if (accept) begin
        if (row_end_in) begin
          row_pos <= '0;
        end else if (row_pos < POS_W'(POS_CAP)) begin
          row_pos <= row_pos + 1'b1;
        end
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    weight_q <= weight_now;
    if (accept) begin
      x_lat    <= row_pos;
      last_lat <= row_end_in;
      d_cnt    <= d_start;
      j_cnt    <= '0;
      divisor  <= DIV_W'(rp1) * DIV_W'(rp1);
    end else if (state == ST_TAPS) begin
      j_cnt <= j_cnt + 1'b1;
    end else if ((state == ST_EMIT) && merge_free && more_results) begin
      d_cnt <= d_cnt - 1'b1;
      j_cnt <= '0;
    end
  end

  `SBR_ASSERT_IMP(a_radius_range, 1'b1, radius_ok, "radius register out of range")
  `SBR_ASSERT_NXT(a_div_restart, lane_ctl.div_start, !div_done, "done survived a divide start")
  `SBR_ASSERT_IMP(a_emit_has_quot, state == ST_EMIT, div_done, "emit without a quotient")
  `SBR_ASSERT_NXT(a_last_to_idle, merge_load && merge_last, state == ST_IDLE, "work after end")

endmodule

// ===== hdl/stack_blur_row_pass_top.sv =====
// Row stack blur: each item that owes a word goes through the tap walk, divide and emit.
// Taps are read one per cycle from the single window read port, then each channel
// lane runs an eight-step divide; lanes work side by side.
// An item that owes a word stalls the input until its last word is loaded into the
// output register; a row end owes up to r+1 words, and an item that owes none is taken without a stall.
// Reset (rst, synchronous, active high) sets radius 3 and row position 0; window kept.
module stack_blur_row_pass_top import sbr_pkg::*; #(
  parameter int MAX_RADIUS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [RADIUS_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CH_W-1:0]     red_in,
  input  logic [CH_W-1:0]     green_in,
  input  logic [CH_W-1:0]     blue_in,
  input  logic                row_end_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CH_W-1:0]     red_out,
  output logic [CH_W-1:0]     green_out,
  output logic [CH_W-1:0]     blue_out,
  output logic                row_end_out
);

  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int ADDR_W    = $clog2(WIN_DEPTH);
  localparam int POS_W     = $clog2(WIN_DEPTH + 1);
  localparam int EFF_MAX   = (MAX_RADIUS < 63) ? MAX_RADIUS : 63;
  localparam int SUM_W     = $clog2(255 * (EFF_MAX + 1) * (EFF_MAX + 1) + 1);
  localparam int DIV_W     = $clog2((EFF_MAX + 1) * (EFF_MAX + 1) + 1);

  win_ctl_t          win_ctl;
  lane_ctl_t         lane_ctl;
  logic [ADDR_W-1:0] rd_offset;
  logic [PIX_W-1:0]  rd_data;
  logic [DIV_W-1:0]  divisor;
  logic [CH_W-1:0]   quot [NUM_LANES];
  logic [NUM_LANES-1:0] lane_done;
  logic              merge_free;
  logic              merge_load;
  logic              merge_last;

  // Sequencer.
  sbr_ctrl #(
    .MAX_RADIUS (MAX_RADIUS),
    .ADDR_W     (ADDR_W),
    .POS_W      (POS_W),
    .DIV_W      (DIV_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_end_in (row_end_in),
    .win_ctl    (win_ctl),
    .rd_offset  (rd_offset),
    .lane_ctl   (lane_ctl),
    .divisor    (divisor),
    .div_done   (&lane_done),
    .merge_free (merge_free),
    .merge_load (merge_load),
    .merge_last (merge_last)
  );

  // Pixel window.
  sbr_window #(
    .ADDR_W (ADDR_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctl       (win_ctl),
    .wr_data   ({red_in, green_in, blue_in}),
    .rd_offset (rd_offset),
    .rd_data   (rd_data)
  );

  // One lane per color channel, red in the top byte of the window word.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sbr_lane #(
      .SUM_W (SUM_W),
      .DIV_W (DIV_W)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (lane_ctl),
      .pixel    (rd_data[PIX_W-1-CH_W*g -: CH_W]),
      .divisor  (divisor),
      .quotient (quot[g]),
      .done     (lane_done[g])
    );
  end

  // Merge and output register.
  sbr_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (merge_load),
    .quot        (quot),
    .last        (merge_last),
    .free        (merge_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .row_end_out (row_end_out)
  );

endmodule
